/* rtl/ucre_pkg.sv */
`timescale 1ns / 1ps

package ucre_pkg;

	// Serial frame: start bit, eight data bits LSB first, stop bit.
	localparam int unsigned FrameBits = 10;

	localparam logic [3:0] FRAME_BITS = 4'(FrameBits);

	// Reset values of the timing registers.
	localparam logic [15:0] BIT_TICKS_RESET      = 16'd104;
	localparam logic [14:0] HALF_BIT_TICKS_RESET = 15'd52;

	// Relay command characters.
	localparam logic [7:0] CMD_SET_A   = 8'h49; // 'I'
	localparam logic [7:0] CMD_SET_B   = 8'h4A; // 'J'
	localparam logic [7:0] CMD_CLEAR_A = 8'h4F; // 'O'
	localparam logic [7:0] CMD_CLEAR_B = 8'h50; // 'P'

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_BIT_TICKS      = 1'b0,
		CFG_HALF_BIT_TICKS = 1'b1
	} cfg_idx_t;

	// Line activity of the half-duplex port.
	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_RECV = 3'b010,
		MODE_SEND = 3'b100
	} mode_t;

endpackage

/* rtl/uart_command_relay_echo.sv */
`timescale 1ns / 1ps
// A tick accepted on the input side is captured in the input register. Its result is then
// loaded into the output register, from which it is offered, when that register is empty
// or its current result is transferring out.
// Throughput: one tick per clock cycle while the output channel is not stalled.
// Reset (arst_n low, asynchronous): line idle, relay state energized, last byte zero,
// bit_ticks 104, half_bit_ticks 52, both pipeline registers empty.
module uart_command_relay_echo (
	input  logic                clk,
	input  logic                arst_n,
	// Tick channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                rxd,
	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                txd,
	output logic                relay_a,
	output logic                relay_b,
	output logic                rx_strobe,
	output logic [7:0]          rx_data,
	output logic                frame_error,
	// Configuration write port
	input  logic                cfg_we,
	input  ucre_pkg::cfg_idx_t  cfg_index,
	input  logic [15:0]         cfg_data
);
	import ucre_pkg::*;

	// Configuration registers.
	logic [15:0] bit_ticks_q;
	logic [14:0] half_bit_ticks_q;

	// Input stage: one sampled receive level per transfer.
	logic valid_s1;
	logic rxd_s1;

	// Output stage: the result of the tick, as seen after its state update.
	logic       valid_s2;
	logic       txd_s2;
	logic       relay_a_s2;
	logic       relay_b_s2;
	logic       rx_strobe_s2;
	logic [7:0] rx_data_s2;
	logic       frame_error_s2;

	// Persistent line state.
	mode_t       mode_q;
	logic        line_prev_q;
	logic [15:0] tick_timer_q;
	logic [3:0]  bits_left_q;
	logic [9:0]  frame_shift_q;
	logic        line_out_q;
	logic        relay_a_q;
	logic        relay_b_q;
	logic [7:0]  last_byte_q;

	// Next-state values.
	mode_t       mode_d;
	logic [15:0] tick_timer_d;
	logic [3:0]  bits_left_d;
	logic [9:0]  frame_shift_d;
	logic        line_out_d;
	logic        relay_a_d;
	logic        relay_b_d;
	logic [7:0]  last_byte_d;
	logic        strobe_d;
	logic        ferr_d;

	logic       advance;
	logic       start_edge;
	logic       fires;
	logic [3:0] bits_dec;
	logic [9:0] rx_shift;
	logic [7:0] rx_byte;

	// The output register can take a new result when it is empty or its
	// current result is being transferred out this cycle. The tick held in
	// the input stage moves on at exactly those edges, which is also when
	// the line state is updated.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign start_edge = line_prev_q && !rxd_s1;
	// The period timer expires when it has counted down to one or below;
	// a period of zero therefore behaves like a period of one.
	assign fires    = (tick_timer_q <= 16'd1);
	assign bits_dec = bits_left_q - 4'd1;
	// Receive samples enter at the top so that after ten of them the start
	// bit sits at bit 0 and the stop bit at bit 9.
	assign rx_shift = {rxd_s1, frame_shift_q[9:1]};
	assign rx_byte  = rx_shift[8:1];

	always_comb begin
		mode_d        = mode_q;
		tick_timer_d  = tick_timer_q;
		bits_left_d   = bits_left_q;
		frame_shift_d = frame_shift_q;
		line_out_d    = line_out_q;
		relay_a_d     = relay_a_q;
		relay_b_d     = relay_b_q;
		last_byte_d   = last_byte_q;
		strobe_d      = 1'b0;
		ferr_d        = 1'b0;

		if (mode_q != MODE_RECV && start_edge) begin
			// A start edge also cuts short any echo in progress.
			mode_d        = MODE_RECV;
			line_out_d    = 1'b1;
			tick_timer_d  = {1'b0, half_bit_ticks_q};
			bits_left_d   = FRAME_BITS;
			frame_shift_d = '0;
		end else if (mode_q == MODE_RECV) begin
			if (fires) begin
				tick_timer_d  = bit_ticks_q;
				frame_shift_d = rx_shift;
				bits_left_d   = bits_dec;
				if (bits_dec == 4'd0) begin
					mode_d = MODE_IDLE;
					if (rx_shift[9] && !rx_shift[0]) begin
						last_byte_d = rx_byte;
						strobe_d    = 1'b1;
						case (rx_byte)
							CMD_SET_A:   relay_a_d = 1'b1;
							CMD_SET_B:   relay_b_d = 1'b1;
							CMD_CLEAR_A: relay_a_d = 1'b0;
							CMD_CLEAR_B: relay_b_d = 1'b0;
							default:     ;
						endcase
						// Echo: one bit time of mark, then the framed byte.
						mode_d        = MODE_SEND;
						line_out_d    = 1'b1;
						frame_shift_d = {1'b1, rx_byte, 1'b0};
						bits_left_d   = FRAME_BITS;
					end else begin
						ferr_d = 1'b1;
					end
				end
			end else begin
				tick_timer_d = tick_timer_q - 16'd1;
			end
		end else if (mode_q == MODE_SEND) begin
			if (fires) begin
				tick_timer_d = bit_ticks_q;
				if (bits_left_q == 4'd0) begin
					mode_d     = MODE_IDLE;
					line_out_d = 1'b1;
				end else begin
					line_out_d    = frame_shift_q[0];
					frame_shift_d = {1'b0, frame_shift_q[9:1]};
					bits_left_d   = bits_dec;
				end
			end else begin
				tick_timer_d = tick_timer_q - 16'd1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q      <= BIT_TICKS_RESET;
			half_bit_ticks_q <= HALF_BIT_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIT_TICKS:      bit_ticks_q      <= cfg_data;
				CFG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data[14:0];
				default:            ;
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rxd_s1 <= rxd;
		end
	end

	// Line state, updated once per tick as it moves to the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			line_prev_q   <= 1'b1;
			tick_timer_q  <= '0;
			bits_left_q   <= '0;
			frame_shift_q <= '0;
			line_out_q    <= 1'b1;
			relay_a_q     <= 1'b1;
			relay_b_q     <= 1'b1;
			last_byte_q   <= '0;
		end else if (advance) begin
			mode_q        <= mode_d;
			line_prev_q   <= rxd_s1;
			tick_timer_q  <= tick_timer_d;
			bits_left_q   <= bits_left_d;
			frame_shift_q <= frame_shift_d;
			line_out_q    <= line_out_d;
			relay_a_q     <= relay_a_d;
			relay_b_q     <= relay_b_d;
			last_byte_q   <= last_byte_d;
		end
	end

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			txd_s2         <= line_out_d;
			relay_a_s2     <= relay_a_d;
			relay_b_s2     <= relay_b_d;
			rx_strobe_s2   <= strobe_d;
			rx_data_s2     <= last_byte_d;
			frame_error_s2 <= ferr_d;
		end
	end

	assign out_valid   = valid_s2;
	assign txd         = txd_s2;
	assign relay_a     = relay_a_s2;
	assign relay_b     = relay_b_s2;
	assign rx_strobe   = rx_strobe_s2;
	assign rx_data     = rx_data_s2;
	assign frame_error = frame_error_s2;

	// The bit counter never runs past one frame.
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= FRAME_BITS)
		else $error("bit counter exceeds frame length");

	// A frame is either delivered or rejected, never both.
	a_strobe_xor_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(rx_strobe_s2 && frame_error_s2))
		else $error("strobe and frame error together");

	// A delivered frame always starts its echo.
	a_strobe_starts_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && strobe_d) |=> (mode_q == MODE_SEND))
		else $error("valid frame did not start the echo");

	// Stalling the tick channel only happens with a tick held in the input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("tick channel stalled without a blocked result");

endmodule
